@@ design/motor_command_frame_decoder_defines.svh @@
// ----------------------------------------------------------------------------
// Motor command frame decoder assertion macros
// Concurrent assertion wrappers shared by the design files. Defining
// ASSERT_OFF removes every check.
// ----------------------------------------------------------------------------
`ifndef MOTOR_COMMAND_FRAME_DECODER_DEFINES_SVH
`define MOTOR_COMMAND_FRAME_DECODER_DEFINES_SVH

`ifndef ASSERT_OFF
// Property holds at every clock edge outside reset.
`define MCFD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("mcfd assertion failed");
// When the antecedent holds, the consequent holds on the following clock edge.
`define MCFD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("mcfd assertion failed");
`else
`define MCFD_ASSERT(lbl, clk, rstn, prop)
`define MCFD_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ design/mcfd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor command frame decoder package
// Frame markers, checksum constants and the decoded result record.
// ----------------------------------------------------------------------------
package mcfd_pkg;

  localparam logic [7:0]  StartMark   = 8'hAA;
  localparam logic [7:0]  EndMark     = 8'h55;
  localparam logic [15:0] FullCompare = 16'hFFFF;

  // Folded byte sums of a 16-bit value that is a multiple of 255.
  localparam logic [8:0] FoldZero = 9'd0;
  localparam logic [8:0] FoldOnce = 9'd255;
  localparam logic [8:0] FoldTwice = 9'd510;

  // Motor targets.
  localparam logic [7:0] StepperA = 8'd0;
  localparam logic [7:0] StepperB = 8'd1;
  localparam logic [7:0] DcMotorA = 8'd2;
  localparam logic [7:0] DcMotorB = 8'd3;

  // Direction codes.
  localparam logic [7:0] DirForward = 8'd0;
  localparam logic [7:0] DirReverse = 8'd1;

  localparam int unsigned OutDataBits = 72;

  typedef struct packed {
    logic        status;
    logic [7:0]  motor_id;
    logic [7:0]  direction;
    logic [15:0] amount;
    logic        step_request;
    logic        drive_update;
    logic [15:0] compare_right;
    logic [15:0] compare_left;
  } result_t;

endpackage

@@ design/mcfd_decode.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor command frame decode
// Detects a complete frame in the byte window, checks its checksum and
// builds the command fields.
// ----------------------------------------------------------------------------
`include "motor_command_frame_decoder_defines.svh"

module mcfd_decode #(
  parameter int unsigned FrameBytes = 8
) (
  input  logic [FrameBytes-1:0][7:0] frame_i,  // position 0 is the oldest byte
  output logic                       frame_hit_o,
  output mcfd_pkg::result_t          result_o
);

  logic [15:0] sum;
  logic [15:0] sum_inv;
  logic [8:0]  fold;
  logic        check_ok;
  logic [7:0]  id;
  logic [7:0]  dir;
  logic [15:0] amount;
  logic        is_stepper;
  logic        is_dc;
  logic        dir_ok;

  assign frame_hit_o = (frame_i[0] == mcfd_pkg::StartMark) &&
                       (frame_i[FrameBytes-1] == mcfd_pkg::EndMark);

  always_comb begin
    sum = '0;
    for (int unsigned k = 0; k < FrameBytes - 1; k++) begin
      sum = sum + {8'd0, frame_i[k]};
    end
  end

  // 2^8 is 1 modulo 255, so the high and low bytes fold into one small sum.
  assign sum_inv  = ~sum;
  assign fold     = {1'b0, sum_inv[15:8]} + {1'b0, sum_inv[7:0]};
  assign check_ok = (fold == mcfd_pkg::FoldZero) || (fold == mcfd_pkg::FoldOnce) ||
                    (fold == mcfd_pkg::FoldTwice);

  assign id     = frame_i[1];
  assign dir    = frame_i[3];
  assign amount = {frame_i[4], frame_i[5]};

  assign is_stepper = (id == mcfd_pkg::StepperA) || (id == mcfd_pkg::StepperB);
  assign is_dc      = (id == mcfd_pkg::DcMotorA) || (id == mcfd_pkg::DcMotorB);
  assign dir_ok     = (dir == mcfd_pkg::DirForward) || (dir == mcfd_pkg::DirReverse);

  always_comb begin
    result_o = '0;
    if (!check_ok) begin
      result_o.status = 1'b1;
    end else begin
      result_o.motor_id     = id;
      result_o.direction    = dir;
      result_o.amount       = amount;
      result_o.step_request = is_stepper;
      if (is_dc && dir_ok) begin
        result_o.drive_update = 1'b1;
        if (dir == mcfd_pkg::DirForward) begin
          result_o.compare_right = mcfd_pkg::FullCompare;
          result_o.compare_left  = amount;
        end else begin
          result_o.compare_right = amount;
          result_o.compare_left  = mcfd_pkg::FullCompare;
        end
      end
    end
  end

endmodule

@@ design/motor_command_frame_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor command frame decoder
// Byte window, frame decode and a registered result stage.
// ----------------------------------------------------------------------------
// Received bytes enter one per clock, while the input is ready, into a window
// of FrameBytes bytes. When the oldest byte is 0xAA and the newest is 0x55 the
// window is decoded as one command frame and cleared, so the next frame needs
// FrameBytes fresh bytes. The input takes one byte every cycle unless stalled;
// the result of a frame appears in the output register on the cycle after its
// closing byte is taken. The output register holds one result, and the input
// stalls only while that result is held by the downstream side. A bad checksum
// gives a result with tuser set and all data bits zero.
`include "motor_command_frame_decoder_defines.svh"

module motor_command_frame_decoder #(
  parameter int unsigned FrameBytes = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] motor_id, [15:8] direction, [31:16] amount, [32] step_request,
  // [33] drive_update, [49:34] compare_right, [65:50] compare_left, rest zero
  output logic [mcfd_pkg::OutDataBits-1:0] m_axis_tdata_o,
  output logic        m_axis_tuser_o    // [0] status
);

  logic [FrameBytes-1:0][7:0] window_q, window_d;
  logic [FrameBytes-1:0][7:0] shifted;
  logic                       in_fire;
  logic                       frame_hit;
  mcfd_pkg::result_t          result;
  mcfd_pkg::result_t          out_q;
  logic                       out_valid_q, out_valid_d;

  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;

  // New byte lands at the newest position; position 0 drops out.
  assign shifted = {s_axis_tdata_i, window_q[FrameBytes-1:1]};

  mcfd_decode #(
    .FrameBytes(FrameBytes)
  ) u_decode (
    .frame_i    (shifted),
    .frame_hit_o(frame_hit),
    .result_o   (result)
  );

  always_comb begin
    window_d    = window_q;
    out_valid_d = out_valid_q;
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
    if (in_fire) begin
      window_d = frame_hit ? '0 : shifted;
      if (frame_hit) begin
        out_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      window_q    <= window_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && frame_hit) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.status;
  assign m_axis_tdata_o  = {6'd0, out_q.compare_left, out_q.compare_right,
                            out_q.drive_update, out_q.step_request, out_q.amount,
                            out_q.direction, out_q.motor_id};

  `MCFD_ASSERT_NEXT(a_frame_gives_result, clk_i, rst_ni,
                    in_fire && frame_hit, m_axis_tvalid_o)
  `MCFD_ASSERT_NEXT(a_frame_clears_window, clk_i, rst_ni,
                    in_fire && frame_hit, window_q == '0)
  `MCFD_ASSERT(a_error_zero_data, clk_i, rst_ni,
               (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o == '0))
  `MCFD_ASSERT(a_one_request_kind, clk_i, rst_ni,
               m_axis_tvalid_o |-> !(out_q.step_request && out_q.drive_update))
  `MCFD_ASSERT(a_drive_full_side, clk_i, rst_ni,
               (m_axis_tvalid_o && out_q.drive_update) |->
               ((out_q.compare_right == mcfd_pkg::FullCompare) ||
                (out_q.compare_left == mcfd_pkg::FullCompare)))

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor command frame decoder testbench
// Streams received bytes into the decoder and checks every decoded frame
// against a byte-window model kept here. A table of hand-made frames comes
// first, then a long mix of random frames, broken frames and line noise.
// Both stream sides idle at random.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned FrameLen = 8;
  localparam int unsigned TotalBytes = 1250;
  localparam int unsigned DirectedRows = 14;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned DrainLimit = 20000;

  // One row of the directed table. Bytes are right aligned and sent from the
  // highest used byte down. With fix_sum set, byte 6 of a full frame is
  // replaced by the byte that makes the checksum good.
  typedef struct packed {
    logic [63:0]       bytes;
    logic [3:0]        len;
    logic              fix_sum;
    logic              typed;
    mcfd_pkg::result_t want;
  } frame_row_t;

  logic                             clk_i;
  logic                             rst_ni;
  logic                             rx_valid = 1'b0;
  logic                             rx_ready;
  logic [7:0]                       rx_byte = 8'h00;
  logic                             tx_valid;
  logic                             tx_ready = 1'b0;
  logic [mcfd_pkg::OutDataBits-1:0] tx_data;
  logic                             tx_status;

  logic [7:0]        rx_window [FrameLen];
  mcfd_pkg::result_t pending_results [$];
  bit                use_typed = 1'b0;
  mcfd_pkg::result_t typed_result;
  bit                src_quiet = 1'b0;
  int                src_switch = 0;

  int mismatches = 0;
  int bytes_sent = 0;
  int frames_taken = 0;
  int results_checked = 0;
  int bad_sums = 0;
  int dc_updates = 0;

  motor_command_frame_decoder DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (rx_valid),
    .s_axis_tready_o (rx_ready),
    .s_axis_tdata_i  (rx_byte),
    .m_axis_tvalid_o (tx_valid),
    .m_axis_tready_i (tx_ready),
    .m_axis_tdata_o  (tx_data),
    .m_axis_tuser_o  (tx_status)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic mcfd_pkg::result_t make_result(input logic status,
                                                    input logic [7:0] id,
                                                    input logic [7:0] dir,
                                                    input logic [15:0] amt,
                                                    input logic step, input logic drv,
                                                    input logic [15:0] right,
                                                    input logic [15:0] left);
    mcfd_pkg::result_t r;
    r.status = status;
    r.motor_id = id;
    r.direction = dir;
    r.amount = amt;
    r.step_request = step;
    r.drive_update = drv;
    r.compare_right = right;
    r.compare_left = left;
    return r;
  endfunction

  // Byte that brings the sum of the first seven frame bytes to a multiple of 255.
  function automatic logic [7:0] checksum_byte(input logic [47:0] head);
    int s;
    int c;
    s = 0;
    for (int i = 0; i < 6; i++) s += head[8*i +: 8];
    c = (255 - s % 255) % 255;
    return c[7:0];
  endfunction

  function automatic frame_row_t directed_row(input int idx);
    frame_row_t r;
    r = '0;
    r.len = 4'd8;
    r.fix_sum = 1'b1;
    case (idx)
      0: begin
        // All-zero body right after reset: the sum is off.
        r.bytes = 64'hAA00_0000_0000_0055;
        r.fix_sum = 1'b0;
        r.typed = 1'b1;
        r.want = make_result(1'b1, 8'd0, 8'd0, 16'd0, 1'b0, 1'b0, 16'd0, 16'd0);
      end
      1: r.bytes = 64'hAA00_0000_0010_0055;
      2: r.bytes = 64'hAA01_5A01_1234_0055;
      3: begin
        r.bytes = 64'hAA02_0000_FFFF_0055;
        r.typed = 1'b1;
        r.want = make_result(1'b0, mcfd_pkg::DcMotorA, mcfd_pkg::DirForward, 16'hFFFF,
                             1'b0, 1'b1, mcfd_pkg::FullCompare, 16'hFFFF);
      end
      4: begin
        r.bytes = 64'hAA03_0001_0000_0055;
        r.typed = 1'b1;
        r.want = make_result(1'b0, mcfd_pkg::DcMotorB, mcfd_pkg::DirReverse, 16'h0000,
                             1'b0, 1'b1, 16'h0000, mcfd_pkg::FullCompare);
      end
      5: r.bytes = 64'hAA03_0000_ABCD_0055;
      6: r.bytes = 64'hAA02_FF01_8001_0055;
      // Direction must come from byte 3, not byte 2.
      7: r.bytes = 64'hAA03_0102_1234_0055;
      // Motor id equal to the start mark; the next row proves the window was cleared.
      8: r.bytes = 64'hAAAA_0000_0000_0055;
      9: begin
        r.bytes = 64'h55;
        r.len = 4'd1;
        r.fix_sum = 1'b0;
      end
      10: r.bytes = 64'hAAFF_FFFF_FFFF_0055;
      11: begin
        r.bytes = 64'hAA_1234_5655;
        r.len = 4'd5;
        r.fix_sum = 1'b0;
      end
      12: r.bytes = 64'hAA00_0001_FFFF_0055;
      default: begin
        r.bytes = 64'hAA02_0000_0005_0755;
        r.fix_sum = 1'b0;
        r.typed = 1'b1;
        r.want = make_result(1'b1, 8'd0, 8'd0, 16'd0, 1'b0, 1'b0, 16'd0, 16'd0);
      end
    endcase
    return r;
  endfunction

  // Shifts one byte into the window and queues the decoded frame, if any.
  function automatic void decode_byte(input logic [7:0] b);
    logic [15:0]       sum;
    logic [7:0]        id;
    logic [7:0]        dir;
    mcfd_pkg::result_t res;
    for (int i = 0; i < FrameLen - 1; i++) rx_window[i] = rx_window[i+1];
    rx_window[FrameLen-1] = b;
    if (rx_window[0] == mcfd_pkg::StartMark && rx_window[FrameLen-1] == mcfd_pkg::EndMark) begin
      res = '0;
      sum = '0;
      for (int i = 0; i < FrameLen - 1; i++) sum = sum + 16'(rx_window[i]);
      sum = ~sum;
      if ((sum % 16'd255) != 16'd0) begin
        res.status = 1'b1;
      end else begin
        id = rx_window[1];
        dir = rx_window[3];
        res.motor_id = id;
        res.direction = dir;
        res.amount = {rx_window[4], rx_window[5]};
        res.step_request = (id == mcfd_pkg::StepperA || id == mcfd_pkg::StepperB);
        if ((id == mcfd_pkg::DcMotorA || id == mcfd_pkg::DcMotorB) &&
            (dir == mcfd_pkg::DirForward || dir == mcfd_pkg::DirReverse)) begin
          res.drive_update = 1'b1;
          res.compare_right = (dir == mcfd_pkg::DirForward) ? mcfd_pkg::FullCompare :
                                                              res.amount;
          res.compare_left = (dir == mcfd_pkg::DirForward) ? res.amount :
                                                             mcfd_pkg::FullCompare;
        end
      end
      pending_results.push_back(use_typed ? typed_result : res);
      frames_taken++;
      for (int i = 0; i < FrameLen; i++) rx_window[i] = 8'h00;
    end
  endfunction

  function automatic int pick_gap(input bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (src_switch == 0) begin
      src_quiet = ($urandom_range(0, 3) == 0);
      src_switch = $urandom_range(40, 200);
    end else begin
      src_switch--;
    end
    gap = pick_gap(src_quiet);
    if (gap > 0) begin
      rx_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk_i); while (!rx_ready);
    decode_byte(b);
    bytes_sent++;
  endtask

  task automatic send_random_frame();
    logic [7:0]  id;
    logic [7:0]  dir;
    logic [7:0]  cs;
    logic [15:0] amt;
    logic [47:0] head;
    int          r;
    int          t;
    id = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
    dir = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 1)) : 8'($urandom_range(0, 255));
    r = $urandom_range(0, 9);
    if (r == 0) amt = 16'h0000;
    else if (r == 1) amt = 16'hFFFF;
    else amt = 16'($urandom_range(0, 65535));
    head = {mcfd_pkg::StartMark, id, 8'($urandom_range(0, 255)), dir, amt};
    cs = checksum_byte(head);
    // 255 is as good as 0 for the check byte.
    if (cs == 8'h00 && $urandom_range(0, 1) == 1) cs = 8'hFF;
    if ($urandom_range(0, 6) == 0) begin
      t = (cs + $urandom_range(1, 254)) % 255;
      cs = t[7:0];
    end
    for (int i = 5; i >= 0; i--) send_byte(head[8*i +: 8]);
    send_byte(cs);
    send_byte(mcfd_pkg::EndMark);
  endtask

  task automatic check_field(input string field_name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", field_name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result();
    mcfd_pkg::result_t want;
    if (pending_results.size() == 0) begin
      $error("result item with no frame outstanding");
      mismatches++;
    end else begin
      want = pending_results.pop_front();
      check_field("status", want.status, tx_status);
      check_field("motor_id", want.motor_id, tx_data[7:0]);
      check_field("direction", want.direction, tx_data[15:8]);
      check_field("amount", want.amount, tx_data[31:16]);
      check_field("step_request", want.step_request, tx_data[32]);
      check_field("drive_update", want.drive_update, tx_data[33]);
      check_field("compare_right", want.compare_right, tx_data[49:34]);
      check_field("compare_left", want.compare_left, tx_data[65:50]);
      check_field("tdata padding", 0, tx_data[mcfd_pkg::OutDataBits-1:66]);
    end
    results_checked++;
    if (tx_status) bad_sums++;
    if (tx_data[33]) dc_updates++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && tx_valid && tx_ready) check_result();
  end

  // Downstream ready: stretches of no stalls, otherwise short and long stalls.
  initial begin
    int stall;
    int until_switch;
    bit quiet;
    stall = 0;
    until_switch = 0;
    quiet = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (until_switch == 0) begin
        quiet = ($urandom_range(0, 3) == 0);
        until_switch = $urandom_range(50, 300);
      end else begin
        until_switch--;
      end
      if (stall == 0) stall = pick_gap(quiet);
      if (stall > 0) begin
        tx_ready <= 1'b0;
        stall--;
      end else begin
        tx_ready <= 1'b1;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    frame_row_t  row;
    logic [7:0]  b;
    int          r;
    int          waited;
    for (int i = 0; i < FrameLen; i++) rx_window[i] = 8'h00;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int idx = 0; idx < DirectedRows; idx++) begin
      row = directed_row(idx);
      use_typed = row.typed;
      typed_result = row.want;
      for (int k = row.len; k > 0; k--) begin
        b = row.bytes[8*k-1 -: 8];
        if (row.fix_sum && row.len == FrameLen && k == 2) b = checksum_byte(row.bytes[63:16]);
        send_byte(b);
      end
      use_typed = 1'b0;
    end

    // Mostly whole frames, plus cut-off frames and loose bytes biased to the marks.
    while (bytes_sent < TotalBytes) begin
      r = $urandom_range(0, 99);
      if (r < 72) begin
        send_random_frame();
      end else if (r < 84) begin
        send_byte(mcfd_pkg::StartMark);
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 6)) begin
          case ($urandom_range(0, 3))
            0: send_byte(mcfd_pkg::StartMark);
            1: send_byte(mcfd_pkg::EndMark);
            default: send_byte(8'($urandom_range(0, 255)));
          endcase
        end
      end
    end
    rx_valid <= 1'b0;

    waited = 0;
    while (pending_results.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (DrainCycles) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      mismatches++;
    end

    $display("Summary: %0d bytes sent, %0d frames decoded by the model, %0d results checked.",
             bytes_sent, frames_taken, results_checked);
    $display("Summary: %0d checksum errors and %0d dc compare updates seen.",
             bad_sums, dc_updates);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
